@@ rtl/lst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants of the link set table: operation and status
// codes, field widths and the layout of one slot of the slot store.
// ----------------------------------------------------------------------------
package lst_pkg;

    // default geometry
    localparam int NUM_ENTRIES_DEF = 64;
    localparam int SLOTS_DEF       = 8;

    // field widths
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 8;
    localparam int INODE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    // one slot: occupied flag over the inode number
    typedef struct packed {
        logic               used;
        logic [INODE_W-1:0] inode;
    } t_slot;

endpackage

@@ rtl/lst_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_store
// Slot store and count store of the link set table, both synchronous
// memories with one write and one registered read port, plus the clearing
// pass that empties every slot and zeroes every count after reset.
// ----------------------------------------------------------------------------
module lst_store #(
    parameter int NUM_ENTRIES     = lst_pkg::NUM_ENTRIES_DEF,
    parameter int SLOTS_PER_ENTRY = lst_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    output logic                                o_clearing,
    input  logic                                i_slot_we,
    input  logic [$clog2(NUM_ENTRIES*SLOTS_PER_ENTRY)-1:0] i_slot_wr_addr,
    input  lst_pkg::t_slot                      i_slot_wr_data,
    input  logic [$clog2(NUM_ENTRIES*SLOTS_PER_ENTRY)-1:0] i_slot_rd_addr,
    output lst_pkg::t_slot                      o_slot_rd_data,
    input  logic                                i_cnt_we,
    input  logic [$clog2(NUM_ENTRIES)-1:0]      i_cnt_wr_addr,
    input  logic [lst_pkg::COUNT_W-1:0]         i_cnt_wr_data,
    input  logic [$clog2(NUM_ENTRIES)-1:0]      i_cnt_rd_addr,
    output logic [lst_pkg::COUNT_W-1:0]         o_cnt_rd_data
);

    localparam int DEPTH = NUM_ENTRIES * SLOTS_PER_ENTRY;
    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int SA_W  = $clog2(DEPTH);

    lst_pkg::t_slot              r_slot_mem [DEPTH];
    logic [lst_pkg::COUNT_W-1:0] r_cnt_mem  [NUM_ENTRIES];
    lst_pkg::t_slot              r_slot_q;
    logic [lst_pkg::COUNT_W-1:0] r_cnt_q;

    logic            r_clearing;
    logic [SA_W-1:0] r_clr;
    logic            clr_cnt;

    // clearing pass walks every slot once, counts ride along on the low rows
    assign clr_cnt = {1'b0, r_clr} < (SA_W + 1)'(NUM_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + SA_W'(1);
            if (r_clr == SA_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_slot_mem[r_clr] <= '0;
        end else if (i_slot_we) begin
            r_slot_mem[i_slot_wr_addr] <= i_slot_wr_data;
        end
        r_slot_q <= r_slot_mem[i_slot_rd_addr];
    end

    // count memory
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            if (clr_cnt) begin
                r_cnt_mem[r_clr[IDX_W-1:0]] <= '0;
            end
        end else if (i_cnt_we) begin
            r_cnt_mem[i_cnt_wr_addr] <= i_cnt_wr_data;
        end
        r_cnt_q <= r_cnt_mem[i_cnt_rd_addr];
    end

    assign o_clearing     = r_clearing;
    assign o_slot_rd_data = r_slot_q;
    assign o_cnt_rd_data  = r_cnt_q;

    // the pass index never leaves the store
    a_clr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> ({1'b0, r_clr} < (SA_W + 1)'(DEPTH)))
        else $error("clearing index beyond store depth");

    // no functional write is taken while the pass runs
    a_no_write_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_slot_we && !i_cnt_we)
        else $error("store written during clearing pass");

    // the pass ends exactly at the last slot
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr) == SA_W'(DEPTH - 1))
        else $error("clearing pass ended early");

endmodule

@@ rtl/link_set_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_set_table_unit
// Table of entries, each a link count and a row of directory inode slots.
// Find, add, remove and query run one item at a time against two memories.
// ----------------------------------------------------------------------------
// After reset a clearing pass over the NUM_ENTRIES*SLOTS_PER_ENTRY slots
// (512 at the defaults) empties the store; the input stalls until it ends.
// Items are then handled one at a time, each reading its entry through the
// single read port of the count and slot memories, one address per cycle.
// Query items read the count, out-of-range items go straight to the result
// register, add and remove read the count and then scan the slots in order,
// stopping at the first slot that matches, and find walks the counts in order
// to the first zero. The result register frees the sequencer, so the next
// item is taken while a result still waits at the output.
module link_set_table_unit #(
    parameter int NUM_ENTRIES     = lst_pkg::NUM_ENTRIES_DEF,
    parameter int SLOTS_PER_ENTRY = lst_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lst_pkg::OP_W-1:0]     i_operation,
    input  logic [lst_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [lst_pkg::INODE_W-1:0]  i_inode_number,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lst_pkg::STATUS_W-1:0] o_status,
    output logic [lst_pkg::FOUND_W-1:0]  o_found_index,
    output logic [lst_pkg::COUNT_W-1:0]  o_link_count,
    output logic                         o_entry_empty
);

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int SA_W   = $clog2(NUM_ENTRIES * SLOTS_PER_ENTRY);
    localparam int SI_W   = $clog2(SLOTS_PER_ENTRY + 1);
    localparam int SCAN_W = $clog2(NUM_ENTRIES + 1);
    localparam int CW     = lst_pkg::COUNT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_SCAN = 5'b00100,
        S_FIND = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    lst_pkg::t_op                 r_op, n_op;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [lst_pkg::INODE_W-1:0]  r_inode, n_inode;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [SA_W-1:0]              r_saddr, n_saddr;
    logic [SI_W-1:0]              r_si, n_si;
    logic [SA_W-1:0]              r_chk_addr, n_chk_addr;
    logic                         r_chk_last, n_chk_last;
    logic                         r_pend, n_pend;
    logic [SCAN_W-1:0]            r_scan, n_scan;
    logic [IDX_W-1:0]             r_fchk, n_fchk;
    lst_pkg::t_status             r_res_status, n_res_status;
    logic [lst_pkg::FOUND_W-1:0]  r_res_found, n_res_found;
    logic [CW-1:0]                r_res_cnt, n_res_cnt;
    logic                         r_res_empty, n_res_empty;
    logic                         r_out_valid, n_out_valid;
    lst_pkg::t_status             r_out_status;
    logic [lst_pkg::FOUND_W-1:0]  r_out_found;
    logic [CW-1:0]                r_out_cnt;
    logic                         r_out_empty;

    logic                         clearing;
    logic                         in_xfer;
    logic                         out_free;
    logic                         in_range;
    lst_pkg::t_op                 in_op;
    logic                         slot_we;
    lst_pkg::t_slot               slot_wr_data;
    lst_pkg::t_slot               slot_q;
    logic                         cnt_we;
    logic [CW-1:0]                cnt_wr_data;
    logic [IDX_W-1:0]             cnt_rd_addr;
    logic [CW-1:0]                cnt_q;
    logic                         slot_issue;
    logic                         find_issue;
    logic                         slot_hit;
    logic [CW-1:0]                new_cnt;

    // storage
    lst_store #(
        .NUM_ENTRIES     (NUM_ENTRIES),
        .SLOTS_PER_ENTRY (SLOTS_PER_ENTRY)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .o_clearing     (clearing),
        .i_slot_we      (slot_we),
        .i_slot_wr_addr (r_chk_addr),
        .i_slot_wr_data (slot_wr_data),
        .i_slot_rd_addr (r_saddr),
        .o_slot_rd_data (slot_q),
        .i_cnt_we       (cnt_we),
        .i_cnt_wr_addr  (r_idx),
        .i_cnt_wr_data  (cnt_wr_data),
        .i_cnt_rd_addr  (cnt_rd_addr),
        .o_cnt_rd_data  (cnt_q)
    );

    // handshakes
    assign o_in_stall = (r_state != S_IDLE) || clearing;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_op      = lst_pkg::t_op'(i_operation);
    assign in_range   = {1'b0, i_entry_index} < (lst_pkg::INDEX_W + 1)'(NUM_ENTRIES);

    // count read follows the input index while idle, the scan pointer in find
    assign cnt_rd_addr = (r_state == S_FIND) ? r_scan[IDX_W-1:0]
                                             : i_entry_index[IDX_W-1:0];

    // slot scan compare on the returning read data
    assign slot_issue = r_si != SI_W'(SLOTS_PER_ENTRY);
    assign find_issue = r_scan != SCAN_W'(NUM_ENTRIES);
    assign slot_hit   = r_pend && ((r_op == lst_pkg::OP_ADD) ? !slot_q.used
                        : (slot_q.used && (slot_q.inode == r_inode)));
    assign new_cnt    = (r_op == lst_pkg::OP_ADD) ? r_cnt + CW'(1)
                        : ((r_cnt != '0) ? r_cnt - CW'(1) : r_cnt);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_inode      = r_inode;
        n_cnt        = r_cnt;
        n_saddr      = r_saddr;
        n_si         = r_si;
        n_chk_addr   = r_chk_addr;
        n_chk_last   = r_chk_last;
        n_pend       = r_pend;
        n_scan       = r_scan;
        n_fchk       = r_fchk;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_cnt    = r_res_cnt;
        n_res_empty  = r_res_empty;
        slot_we      = 1'b0;
        slot_wr_data = '0;
        cnt_we       = 1'b0;
        cnt_wr_data  = new_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op    = in_op;
                    n_idx   = i_entry_index[IDX_W-1:0];
                    n_inode = i_inode_number;
                    n_saddr = SA_W'(SA_W'(i_entry_index[IDX_W-1:0])
                                    * SA_W'(SLOTS_PER_ENTRY));
                    n_si    = '0;
                    n_pend  = 1'b0;
                    n_scan  = '0;
                    n_res_found = '0;
                    if (in_op == lst_pkg::OP_FIND) begin
                        n_state = S_FIND;
                    end else if (!in_range) begin
                        n_res_status = lst_pkg::ST_RANGE;
                        n_res_cnt    = '0;
                        n_res_empty  = 1'b1;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_cnt = cnt_q;
                if (r_op == lst_pkg::OP_QUERY) begin
                    n_res_status = lst_pkg::ST_OK;
                    n_res_cnt    = cnt_q;
                    n_res_empty  = (cnt_q == '0);
                    n_state      = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend = slot_issue;
                if (slot_issue) begin
                    n_saddr    = r_saddr + SA_W'(1);
                    n_si       = r_si + SI_W'(1);
                    n_chk_addr = r_saddr;
                    n_chk_last = (r_si == SI_W'(SLOTS_PER_ENTRY - 1));
                end
                if (slot_hit) begin
                    slot_we = 1'b1;
                    cnt_we  = 1'b1;
                    if (r_op == lst_pkg::OP_ADD) begin
                        slot_wr_data.used  = 1'b1;
                        slot_wr_data.inode = r_inode;
                    end
                    n_res_status = lst_pkg::ST_OK;
                    n_res_cnt    = new_cnt;
                    n_res_empty  = (new_cnt == '0);
                    n_state      = S_RESP;
                end else if (r_pend && r_chk_last) begin
                    n_res_status = (r_op == lst_pkg::OP_ADD) ? lst_pkg::ST_FULL
                                                             : lst_pkg::ST_OK;
                    n_res_cnt    = r_cnt;
                    n_res_empty  = (r_cnt == '0);
                    n_state      = S_RESP;
                end
            end
            S_FIND: begin
                n_pend = find_issue;
                if (find_issue) begin
                    n_scan     = r_scan + SCAN_W'(1);
                    n_fchk     = r_scan[IDX_W-1:0];
                    n_chk_last = (r_scan == SCAN_W'(NUM_ENTRIES - 1));
                end
                n_res_cnt = '0;
                if (r_pend && (cnt_q == '0)) begin
                    n_res_status = lst_pkg::ST_OK;
                    n_res_found  = lst_pkg::FOUND_W'(r_fchk);
                    n_res_empty  = 1'b1;
                    n_state      = S_RESP;
                end else if (r_pend && r_chk_last) begin
                    n_res_status = lst_pkg::ST_NONE;
                    n_res_found  = '0;
                    n_res_empty  = 1'b0;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register load and release
    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == S_RESP) && out_free) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_inode      <= n_inode;
        r_cnt        <= n_cnt;
        r_saddr      <= n_saddr;
        r_si         <= n_si;
        r_chk_addr   <= n_chk_addr;
        r_chk_last   <= n_chk_last;
        r_scan       <= n_scan;
        r_fchk       <= n_fchk;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_cnt    <= n_res_cnt;
        r_res_empty  <= n_res_empty;
        if ((r_state == S_RESP) && out_free) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_cnt    <= r_res_cnt;
            r_out_empty  <= r_res_empty;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_found;
    assign o_link_count  = r_out_cnt;
    assign o_entry_empty = r_out_empty;

    // a slot change always comes with its count change
    a_slot_cnt_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we == cnt_we)
        else $error("slot and count writes out of step");

    // counts reported never exceed the row size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_link_count <= CW'(SLOTS_PER_ENTRY))
        else $error("link count above slot count");

    // a nonzero count never reads as empty
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_link_count != '0) |-> !o_entry_empty)
        else $error("entry reported empty with links");

    // no free entry carries a zero index and a clear empty flag
    a_none_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == lst_pkg::ST_NONE)
        |-> (o_found_index == '0) && !o_entry_empty)
        else $error("bad fields on no free entry");

    // an accepted item always leaves idle
    a_xfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != S_IDLE)
        else $error("transfer in without leaving idle");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for link_set_table_unit
// Drives find, add, remove and query items through the input channel and
// checks every reply against a table model kept here, in transfer order.
// Directed items cover reset state, out-of-range indexes, a full entry,
// duplicate and unmatched removes; random traffic then works a few hot
// entries hard, fills the whole table, and frees parts of it again.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES = lst_pkg::NUM_ENTRIES_DEF;
    localparam int SLOTS   = lst_pkg::SLOTS_DEF;

    // one expected reply
    typedef struct packed {
        lst_pkg::t_status             status;
        logic [lst_pkg::FOUND_W-1:0]  found;
        logic [lst_pkg::COUNT_W-1:0]  count;
        logic                         empty;
    } t_table_reply;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_stall;
    logic [lst_pkg::OP_W-1:0]     i_operation    = '0;
    logic [lst_pkg::INDEX_W-1:0]  i_entry_index  = '0;
    logic [lst_pkg::INODE_W-1:0]  i_inode_number = '0;
    logic                         o_out_valid;
    logic                         i_out_stall    = 1'b0;
    logic [lst_pkg::STATUS_W-1:0] o_status;
    logic [lst_pkg::FOUND_W-1:0]  o_found_index;
    logic [lst_pkg::COUNT_W-1:0]  o_link_count;
    logic                         o_entry_empty;

    // table model
    bit                        slot_used  [ENTRIES][SLOTS];
    bit [lst_pkg::INODE_W-1:0] slot_inode [ENTRIES][SLOTS];
    bit [lst_pkg::COUNT_W-1:0] link_total [ENTRIES];

    t_table_reply expected_replies[$];
    int           error_count = 0;
    bit           idle_on     = 1'b1;
    int           stall_left  = 0;

    link_set_table_unit #(
        .NUM_ENTRIES     (ENTRIES),
        .SLOTS_PER_ENTRY (SLOTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_inode_number (i_inode_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_link_count   (o_link_count),
        .o_entry_empty  (o_entry_empty)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // table model: apply one operation, return the reply it gives
    task automatic predict_reply(input lst_pkg::t_op op,
                                 input logic [lst_pkg::INDEX_W-1:0] idx,
                                 input logic [lst_pkg::INODE_W-1:0] inode,
                                 output t_table_reply r);
        int  e;
        bit  done;
        e    = idx;
        done = 1'b0;
        r    = '{status: lst_pkg::ST_OK, found: '0, count: '0, empty: 1'b0};
        if (op == lst_pkg::OP_FIND) begin
            r.status = lst_pkg::ST_NONE;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!done && link_total[i] == 0) begin
                    r.status = lst_pkg::ST_OK;
                    r.found  = lst_pkg::FOUND_W'(i);
                    r.empty  = 1'b1;
                    done     = 1'b1;
                end
            end
        end else if (e >= ENTRIES) begin
            r.status = lst_pkg::ST_RANGE;
            r.empty  = 1'b1;
        end else begin
            if (op == lst_pkg::OP_ADD) begin
                r.status = lst_pkg::ST_FULL;
                for (int s = 0; s < SLOTS; s++) begin
                    if (!done && !slot_used[e][s]) begin
                        slot_used[e][s]  = 1'b1;
                        slot_inode[e][s] = inode;
                        link_total[e]    = link_total[e] + 1'b1;
                        r.status         = lst_pkg::ST_OK;
                        done             = 1'b1;
                    end
                end
            end else if (op == lst_pkg::OP_REMOVE) begin
                // only the lowest matching slot is freed
                for (int s = 0; s < SLOTS; s++) begin
                    if (!done && slot_used[e][s] && slot_inode[e][s] == inode) begin
                        slot_used[e][s]  = 1'b0;
                        slot_inode[e][s] = '0;
                        if (link_total[e] != 0)
                            link_total[e] = link_total[e] - 1'b1;
                        done = 1'b1;
                    end
                end
            end
            r.count = link_total[e];
            r.empty = (link_total[e] == 0);
        end
    endtask

    // one input transfer, with an optional gap before it
    task automatic send_item(input lst_pkg::t_op op,
                             input logic [lst_pkg::INDEX_W-1:0] idx,
                             input logic [lst_pkg::INODE_W-1:0] inode);
        t_table_reply want;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_entry_index  <= idx;
        i_inode_number <= inode;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_reply(op, idx, inode, want);
        expected_replies.push_back(want);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // output side stalls in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(1, 6) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each reply transfer with the oldest expectation
    always @(posedge i_clk) begin : reply_check
        t_table_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: reply with none expected, actual status %0d count %0d",
                         $time, o_status, o_link_count);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("status", want.status, o_status);
                check_field("found_index", want.found, o_found_index);
                check_field("link_count", want.count, o_link_count);
                check_field("entry_empty", want.empty, o_entry_empty);
            end
        end
    end

    // fresh table: everything empty, find lands on entry 0
    task automatic test_after_reset();
        send_item(lst_pkg::OP_QUERY, 8'd0, 16'h0000);
        send_item(lst_pkg::OP_QUERY, lst_pkg::INDEX_W'(ENTRIES - 1), 16'hFFFF);
        send_item(lst_pkg::OP_FIND, 8'hFF, 16'hFFFF);
    endtask

    // indexes at and above the table size
    task automatic test_index_range();
        send_item(lst_pkg::OP_ADD, lst_pkg::INDEX_W'(ENTRIES), 16'h1234);
        send_item(lst_pkg::OP_REMOVE, 8'hFF, 16'h0000);
        send_item(lst_pkg::OP_QUERY, 8'h80, 16'hFFFF);
    endtask

    // fill entry 0 with a duplicate, overflow it, then remove
    task automatic test_fill_entry();
        send_item(lst_pkg::OP_ADD, 8'd0, 16'h0000);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'hFFFF);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'h1234);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'h1234);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'h0001);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'h8000);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'h00FF);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'hFF00);
        send_item(lst_pkg::OP_ADD, 8'd0, 16'h5555);
        send_item(lst_pkg::OP_FIND, 8'd0, 16'h0000);
        send_item(lst_pkg::OP_REMOVE, 8'd0, 16'h1234);
        send_item(lst_pkg::OP_REMOVE, 8'd0, 16'hAAAA);
        send_item(lst_pkg::OP_QUERY, 8'd0, 16'h0000);
    endtask

    // random mix, most traffic on a few hot entries so they fill and drain
    task automatic test_random_traffic(input int n, input int hot_span);
        int                          roll;
        int                          e;
        int                          k;
        lst_pkg::t_op                op;
        logic [lst_pkg::INDEX_W-1:0] idx;
        logic [lst_pkg::INODE_W-1:0] inode;
        for (int j = 0; j < n; j++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 70)
                e = $urandom_range(0, hot_span - 1);
            else
                e = $urandom_range(0, ENTRIES - 1);
            idx = lst_pkg::INDEX_W'(e);
            if ($urandom_range(0, 1) == 0)
                inode = lst_pkg::INODE_W'($urandom_range(0, 3));
            else
                inode = lst_pkg::INODE_W'($urandom);
            if (roll < 36) begin
                op = lst_pkg::OP_ADD;
            end else if (roll < 68) begin
                op = lst_pkg::OP_REMOVE;
                // mostly remove an inode the entry really holds
                if (link_total[e] != 0 && $urandom_range(0, 4) != 0) begin
                    k = $urandom_range(0, SLOTS - 1);
                    while (!slot_used[e][k]) k = (k + 1) % SLOTS;
                    inode = slot_inode[e][k];
                end
            end else if (roll < 84) begin
                op = lst_pkg::OP_QUERY;
            end else if (roll < 93) begin
                op  = lst_pkg::OP_FIND;
                idx = lst_pkg::INDEX_W'($urandom);
            end else begin
                op  = lst_pkg::t_op'($urandom_range(1, 3));
                idx = lst_pkg::INDEX_W'($urandom_range(ENTRIES, 255));
            end
            send_item(op, idx, inode);
        end
    endtask

    // occupy every entry so find has nothing, then free some again
    task automatic test_table_exhaust();
        bit touched [ENTRIES];
        for (int e = 0; e < ENTRIES; e++) begin
            touched[e] = (link_total[e] == 0);
            if (touched[e])
                send_item(lst_pkg::OP_ADD, lst_pkg::INDEX_W'(e),
                          lst_pkg::INODE_W'($urandom));
        end
        send_item(lst_pkg::OP_FIND, lst_pkg::INDEX_W'($urandom),
                  lst_pkg::INODE_W'($urandom));
        send_item(lst_pkg::OP_QUERY, lst_pkg::INDEX_W'($urandom_range(0, ENTRIES - 1)),
                  16'h0000);
        for (int e = 0; e < ENTRIES; e++) begin
            if (touched[e] && $urandom_range(0, 1) == 0)
                send_item(lst_pkg::OP_REMOVE, lst_pkg::INDEX_W'(e), slot_inode[e][0]);
        end
        send_item(lst_pkg::OP_FIND, 8'd0, 16'h0000);
    endtask

    // main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_index_range();
        test_fill_entry();
        test_random_traffic(600, 4);
        test_table_exhaust();
        test_random_traffic(600, 8);
        test_table_exhaust();
        idle_on <= 1'b0;
        test_random_traffic(400, 4);
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, expected_replies.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lst_pkg.sv
rtl/lst_store.sv
rtl/link_set_table_unit.sv
sim/testbench.sv
